// ----- design/qea_pkg.sv -----
// Shared types and constants for the quadrature encoder position block.
// Used by the divider and the core; depends on nothing else.
`default_nettype none

package qea_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_ENABLE   = 3'd0;
	localparam logic [2:0] CFG_STEPS    = 3'd1;
	localparam logic [2:0] CFG_MIN      = 3'd2;
	localparam logic [2:0] CFG_MAX      = 3'd3;
	localparam logic [2:0] CFG_WRAP     = 3'd4;
	localparam logic [2:0] CFG_COEF     = 3'd5;
	localparam logic [2:0] CFG_OFFSET   = 3'd6;

	// Configuration reset values
	localparam logic              RST_ENABLE = 1'b1;
	localparam logic        [7:0] RST_STEPS  = 8'd2;
	localparam logic signed [31:0] RST_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] RST_MAX   = 32'sh7FFF_FFFF;
	localparam logic              RST_WRAP   = 1'b0;
	localparam logic       [15:0] RST_COEF   = 16'd150;
	localparam logic signed [7:0] RST_OFFSET = 8'sd2;

	// 32-bit signed range, used for saturation of the raw count
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

	// Acceleration timing window (ms)
	localparam logic [31:0] ACCEL_LONG_MS  = 32'd200;
	localparam logic  [7:0] ACCEL_SHORT_MS = 8'd4;

	// Divider geometry: 36-bit dividend, 4 quotient bits per cycle
	localparam int DIV_W      = 36;
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = DIV_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic signed [1:0] DIR_NONE = 2'sd0;
	localparam logic signed [1:0] DIR_POS  = 2'sd1;

	typedef struct packed {
		logic                    start;
		logic signed [DIV_W-1:0] dividend;
		logic            [7:0]   divisor;
	} qea_div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DIV_W-1:0] quot;
	} qea_div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_GOT_HI,
		ST_GOT_LO,
		ST_GOT_Q0,
		ST_DISPATCH,
		ST_STEP,
		ST_ACCEL,
		ST_R2,
		ST_LIMIT,
		ST_SET_LIM,
		ST_NEWQ,
		ST_DIV,
		ST_OUT
	} qea_state_t;

	// Quadrature transition table: index is {prev_b, prev_a, b, a}
	function automatic logic signed [1:0] step_dir(input logic [3:0] idx);
		logic signed [1:0] d;
		case (idx) inside
			4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
			default:                  d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- design/qea_div.sv -----
// Iterative signed-by-unsigned divider, truncating toward zero.
// Four restoring steps per cycle on an 8-bit divisor; uses qea_pkg.
`default_nettype none

module qea_div (
	input  wire                   clk,
	input  wire                   arst_n,
	input  qea_pkg::qea_div_req_t req,
	output qea_pkg::qea_div_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic                            neg_q;
	logic [qea_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [qea_pkg::DIV_W-1:0]       num_q;
	logic [7:0]                      rem_q;
	logic [7:0]                      div_q;

	logic [qea_pkg::DIV_W-1:0]       num_v;
	logic [7:0]                      rem_v;
	logic [8:0]                      trial;
	logic [qea_pkg::DIV_W-1:0]       mag;

	// magnitude of the dividend
	assign mag = req.dividend[qea_pkg::DIV_W-1] ? qea_pkg::DIV_W'(-req.dividend)
		: qea_pkg::DIV_W'(req.dividend);

	// four shift-subtract steps per cycle
	always_comb begin
		rem_v = rem_q;
		num_v = num_q;
		trial = '0;
		for (int i = 0; i < qea_pkg::DIV_BITS; i++) begin
			trial = {rem_v, num_v[qea_pkg::DIV_W-1]};
			num_v = {num_v[qea_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_v    = 8'(trial - {1'b0, div_q});
				num_v[0] = 1'b1;
			end else begin
				rem_v = trial[7:0];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == qea_pkg::DIV_CNT_W'(qea_pkg::DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= mag;
			rem_q <= '0;
			div_q <= req.divisor;
			neg_q <= req.dividend[qea_pkg::DIV_W-1];
		end else if (busy_q) begin
			num_q <= num_v;
			rem_q <= rem_v;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

`default_nettype wire

// ----- design/quadrature_encoder_accel_position_core.sv -----
// A sample without a step or a disabled sample needs no division; a step, an
// accelerated step and a set position use the shared divider for each division.
// The first item after reset or after a write to steps, min_count or max_count
// first refreshes the cached limit quotients and the raw-count quotient on it.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: asynchronous, active low; work and payload registers lack reset values.
// Top level of the quadrature encoder position block; uses qea_pkg and qea_div.
`default_nettype none

module quadrature_encoder_accel_position_core (
	input  wire                clk,
	input  wire                arst_n,
	// input channel
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                opcode,
	input  wire                pin_a,
	input  wire                pin_b,
	input  wire         [31:0] now_ms,
	input  wire  signed [31:0] new_value,
	// result channel
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] position,
	output logic signed [31:0] change,
	output logic signed [1:0]  direction,
	// configuration channel
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire         [2:0]  cfg_index,
	input  wire         [31:0] cfg_data
);

	localparam int W = qea_pkg::DIV_W;

	// configuration
	logic               enable_q;
	logic        [7:0]  steps_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic               wrap_q;
	logic        [15:0] coef_q;
	logic signed [7:0]  offset_q;

	// decoder state
	logic        [1:0]  prev_ab_q;
	logic signed [31:0] raw_q;
	logic signed [1:0]  last_dir_q;
	logic        [31:0] last_move_q;
	logic signed [31:0] last_rep_q;

	// cached quotients
	logic               dirty_q;
	logic signed [31:0] hi_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] qraw_q;

	// current item and work registers
	logic               op_q;
	logic        [1:0]  ab_q;
	logic        [31:0] now_q;
	logic signed [31:0] newv_q;
	logic signed [1:0]  dir_q;
	logic signed [40:0] r_q;
	logic signed [W-1:0] q_q;

	qea_pkg::qea_state_t   state_q, state_d, ret_q, ret_d;
	qea_pkg::qea_div_req_t div_req;
	qea_pkg::qea_div_rsp_t div_rsp;

	logic               out_valid_q;
	logic signed [31:0] pos_out_q;
	logic signed [31:0] chg_out_q;
	logic signed [1:0]  dir_out_q;

	// derived values
	logic        [7:0]  eff_s;
	logic signed [40:0] s41, min41, max41;
	logic signed [1:0]  dir_tab;
	logic signed [40:0] r_step;
	logic        [31:0] elapsed;
	logic        [7:0]  accel_div;
	logic               step_move;
	logic               accel_go;
	logic signed [40:0] r_accel;
	logic               above, below;
	logic signed [40:0] r_lim;
	logic signed [31:0] raw_sat;
	logic               reuse_q;
	logic signed [40:0] set_prod;
	logic signed [40:0] set_t1, set_t2;
	logic signed [31:0] pos_cur;
	logic               in_xfer, out_free;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != qea_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	assign eff_s = (steps_q == 8'd0) ? 8'd1 : steps_q;
	assign s41   = 41'($signed({1'b0, eff_s}));
	assign min41 = 41'(min_q);
	assign max41 = 41'(max_q);

	// step decode and acceleration terms
	assign dir_tab   = qea_pkg::step_dir({prev_ab_q, ab_q});
	assign r_step    = 41'(raw_q) + 41'(dir_tab);
	assign elapsed   = now_q - last_move_q;
	assign accel_div = (elapsed[7:0] < qea_pkg::ACCEL_SHORT_MS) ? qea_pkg::ACCEL_SHORT_MS
		: elapsed[7:0];
	assign step_move = (div_rsp.quot != W'(qraw_q)) && (coef_q > 16'd1);
	assign accel_go  = step_move && (dir_q == last_dir_q) && (elapsed < qea_pkg::ACCEL_LONG_MS);
	assign r_accel   = (dir_q == qea_pkg::DIR_POS) ? r_q + 41'(div_rsp.quot)
		: r_q - 41'(div_rsp.quot);

	// limit handling on the stepped raw count
	assign above = q_q > W'(hi_q);
	assign below = q_q < W'(lo_q);
	always_comb begin
		if (above) begin
			r_lim = wrap_q ? min41 - (max41 + s41 - r_q) : max41;
		end else if (below) begin
			r_lim = wrap_q ? max41 + max41 + min41 + s41 : min41;
		end else begin
			r_lim = r_q;
		end
		if (r_lim > 41'(qea_pkg::S32_MAX)) begin
			raw_sat = qea_pkg::S32_MAX;
		end else if (r_lim < 41'(qea_pkg::S32_MIN)) begin
			raw_sat = qea_pkg::S32_MIN;
		end else begin
			raw_sat = r_lim[31:0];
		end
	end
	assign reuse_q = (41'(raw_sat) == r_q);

	// set position: load and limit
	assign set_prod = 41'(newv_q) * s41 + 41'(offset_q);
	assign set_t1 = (r_q > max41) ? (wrap_q ? min41 : max41) : r_q;
	assign set_t2 = (set_t1 < min41) ? (wrap_q ? max41 : min41) : set_t1;

	// reported position, clamped to the limit quotients
	assign pos_cur = (qraw_q > hi_q) ? hi_q : (qraw_q < lo_q) ? lo_q : qraw_q;

	qea_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			qea_pkg::ST_IDLE:     if (in_xfer) state_d = qea_pkg::ST_CHECK;
			qea_pkg::ST_CHECK:    state_d = dirty_q ? qea_pkg::ST_DIV : qea_pkg::ST_DISPATCH;
			qea_pkg::ST_GOT_HI:   state_d = qea_pkg::ST_DIV;
			qea_pkg::ST_GOT_LO:   state_d = qea_pkg::ST_DIV;
			qea_pkg::ST_GOT_Q0:   state_d = qea_pkg::ST_DISPATCH;
			qea_pkg::ST_DISPATCH: begin
				if (op_q) begin
					state_d = qea_pkg::ST_SET_LIM;
				end else if (enable_q && (dir_tab != qea_pkg::DIR_NONE)) begin
					state_d = qea_pkg::ST_DIV;
				end else begin
					state_d = qea_pkg::ST_OUT;
				end
			end
			qea_pkg::ST_STEP:     state_d = accel_go ? qea_pkg::ST_DIV : qea_pkg::ST_LIMIT;
			qea_pkg::ST_ACCEL:    state_d = qea_pkg::ST_DIV;
			qea_pkg::ST_R2:       state_d = qea_pkg::ST_LIMIT;
			qea_pkg::ST_LIMIT:    state_d = reuse_q ? qea_pkg::ST_OUT : qea_pkg::ST_DIV;
			qea_pkg::ST_SET_LIM:  state_d = qea_pkg::ST_DIV;
			qea_pkg::ST_NEWQ:     state_d = qea_pkg::ST_OUT;
			qea_pkg::ST_DIV:      if (div_rsp.done) state_d = ret_q;
			qea_pkg::ST_OUT:      if (out_free) state_d = qea_pkg::ST_IDLE;
			default:              state_d = qea_pkg::ST_IDLE;
		endcase
	end

	// divider requests and return points
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = eff_s;
		ret_d            = ret_q;
		case (state_q)
			qea_pkg::ST_CHECK: begin
				div_req.start    = dirty_q;
				div_req.dividend = W'(max_q);
				ret_d            = qea_pkg::ST_GOT_HI;
			end
			qea_pkg::ST_GOT_HI: begin
				div_req.start    = 1'b1;
				div_req.dividend = W'(min_q);
				ret_d            = qea_pkg::ST_GOT_LO;
			end
			qea_pkg::ST_GOT_LO: begin
				div_req.start    = 1'b1;
				div_req.dividend = W'(raw_q);
				ret_d            = qea_pkg::ST_GOT_Q0;
			end
			qea_pkg::ST_DISPATCH: begin
				div_req.start    = !op_q && enable_q && (dir_tab != qea_pkg::DIR_NONE);
				div_req.dividend = r_step[W-1:0];
				ret_d            = qea_pkg::ST_STEP;
			end
			qea_pkg::ST_STEP: begin
				div_req.start    = accel_go;
				div_req.dividend = W'($signed({1'b0, coef_q}));
				div_req.divisor  = accel_div;
				ret_d            = qea_pkg::ST_ACCEL;
			end
			qea_pkg::ST_ACCEL: begin
				div_req.start    = 1'b1;
				div_req.dividend = r_accel[W-1:0];
				ret_d            = qea_pkg::ST_R2;
			end
			qea_pkg::ST_LIMIT: begin
				div_req.start    = !reuse_q;
				div_req.dividend = W'(raw_sat);
				ret_d            = qea_pkg::ST_NEWQ;
			end
			qea_pkg::ST_SET_LIM: begin
				div_req.start    = 1'b1;
				div_req.dividend = W'($signed(set_t2[31:0]));
				ret_d            = qea_pkg::ST_NEWQ;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qea_pkg::ST_IDLE;
			ret_q   <= qea_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			if (div_req.start) ret_q <= ret_d;
		end
	end

	// configuration registers and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= qea_pkg::RST_ENABLE;
			steps_q     <= qea_pkg::RST_STEPS;
			min_q       <= qea_pkg::RST_MIN;
			max_q       <= qea_pkg::RST_MAX;
			wrap_q      <= qea_pkg::RST_WRAP;
			coef_q      <= qea_pkg::RST_COEF;
			offset_q    <= qea_pkg::RST_OFFSET;
			prev_ab_q   <= '0;
			raw_q       <= '0;
			last_dir_q  <= qea_pkg::DIR_NONE;
			last_move_q <= '0;
			last_rep_q  <= '0;
			dirty_q     <= 1'b1;
			hi_q        <= '0;
			lo_q        <= '0;
			qraw_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// register writes; steps and limits invalidate the cached quotients
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					qea_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
					qea_pkg::CFG_STEPS: begin
						steps_q <= cfg_data[7:0];
						dirty_q <= 1'b1;
					end
					qea_pkg::CFG_MIN: begin
						min_q   <= $signed(cfg_data);
						dirty_q <= 1'b1;
					end
					qea_pkg::CFG_MAX: begin
						max_q   <= $signed(cfg_data);
						dirty_q <= 1'b1;
					end
					qea_pkg::CFG_WRAP:   wrap_q   <= cfg_data[0];
					qea_pkg::CFG_COEF:   coef_q   <= cfg_data[15:0];
					qea_pkg::CFG_OFFSET: offset_q <= $signed(cfg_data[7:0]);
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			case (state_q)
				qea_pkg::ST_GOT_HI: hi_q <= div_rsp.quot[31:0];
				qea_pkg::ST_GOT_LO: lo_q <= div_rsp.quot[31:0];
				qea_pkg::ST_GOT_Q0: begin
					qraw_q  <= div_rsp.quot[31:0];
					dirty_q <= 1'b0;
				end
				qea_pkg::ST_DISPATCH: begin
					if (!op_q && enable_q) prev_ab_q <= ab_q;
				end
				qea_pkg::ST_STEP: begin
					if (step_move) begin
						last_move_q <= now_q;
						last_dir_q  <= dir_q;
					end
				end
				qea_pkg::ST_LIMIT: begin
					raw_q <= raw_sat;
					if (reuse_q) qraw_q <= q_q[31:0];
				end
				qea_pkg::ST_SET_LIM: raw_q <= set_t2[31:0];
				qea_pkg::ST_NEWQ: qraw_q <= div_rsp.quot[31:0];
				qea_pkg::ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						last_rep_q  <= pos_cur;
					end
				end
				default: ;
			endcase
		end
	end

	// item capture, work registers and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= opcode;
			ab_q   <= {pin_b, pin_a};
			now_q  <= now_ms;
			newv_q <= new_value;
		end
		case (state_q)
			qea_pkg::ST_DISPATCH: begin
				if (op_q) begin
					r_q   <= set_prod;
					dir_q <= qea_pkg::DIR_NONE;
				end else if (enable_q) begin
					r_q   <= r_step;
					dir_q <= dir_tab;
				end else begin
					dir_q <= qea_pkg::DIR_NONE;
				end
			end
			qea_pkg::ST_STEP:   q_q <= div_rsp.quot;
			qea_pkg::ST_ACCEL:  r_q <= r_accel;
			qea_pkg::ST_R2:     q_q <= div_rsp.quot;
			qea_pkg::ST_OUT: begin
				if (out_free) begin
					pos_out_q <= pos_cur;
					chg_out_q <= op_q ? 32'sd0 : pos_cur - last_rep_q;
					dir_out_q <= dir_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign position  = pos_out_q;
	assign change    = chg_out_q;
	assign direction = dir_out_q;

endmodule

`default_nettype wire

// ----- design/qea_checker.sv -----
// Port-level checks for the quadrature encoder position core, with the bind
// that attaches them to the top level; uses only the top level's ports.
`default_nettype none

module qea_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [31:0] position,
	input wire signed [31:0] change,
	input wire signed [1:0]  direction
);

	// an accepted item keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	// a result only appears when an item was in flight
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in flight");

	// the table step is never -2
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> direction != 2'b10)
		else $error("illegal direction code");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(change)
			&& $stable(direction))
		else $error("stalled result changed");

endmodule

bind quadrature_encoder_accel_position_core qea_checker u_qea_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.position  (position),
	.change    (change),
	.direction (direction)
);

`default_nettype wire
